// ----- rtl/rds_pkg.sv -----
`default_nettype none

package rds_pkg;

    // field widths
    localparam int DELAY_W   = 8;
    localparam int MARK_W    = 4;
    localparam int MAX_CHANS = 8;
    localparam int CFG_W     = DELAY_W * MAX_CHANS;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_OPEN_DELAYS  = 2'd0,
        CFG_CLOSE_DELAYS = 2'd1,
        CFG_CHAN_ENABLE  = 2'd2,
        CFG_UNUSED       = 2'd3
    } t_cfg_idx;

    typedef logic [DELAY_W-1:0] t_byte;
    typedef logic [MARK_W-1:0]  t_mark;

    localparam t_byte CHAN_ENABLE_RST = 8'hFF;

endpackage

`default_nettype wire

// ----- rtl/rds_in_if.sv -----
`default_nettype none

interface rds_in_if;
    logic valid;
    logic ready;
    logic second_tick;
    logic key_pressed;

    modport source (output valid, output second_tick, output key_pressed, input ready);
    modport sink   (input valid, input second_tick, input key_pressed, output ready);
endinterface

`default_nettype wire

// ----- rtl/rds_out_if.sv -----
`default_nettype none

interface rds_out_if;
    logic                valid;
    logic                ready;
    rds_pkg::t_byte      fired_second;
    rds_pkg::t_byte      relay_bits;
    logic                dir_open;
    logic                in_progress;

    modport source (output valid, output fired_second, output relay_bits,
                    output dir_open, output in_progress, input ready);
    modport sink   (input valid, input fired_second, input relay_bits,
                    input dir_open, input in_progress, output ready);
endinterface

`default_nettype wire

// ----- rtl/relay_delay_sequencer.sv -----
// relay delay sequencer
// i_item carries one poll: a one-second tick and a key-press flag. each accepted
// transaction produces exactly one result transaction on o_result with the
// fired second, the relay drive and the direction and in-progress flags.
// the config port (i_cfg_we, i_cfg_idx, i_cfg_data) writes the open delays,
// close delays and channel enable; write it only while the block is idle.
// the result is registered and valid in the cycle after the input is accepted.
// throughput: one poll per cycle unless a stalled receiver holds the result;
// the step is a single pass of parallel byte compares and a small max chain
// between the state registers and the result register.
// i_item.ready is high while the result register is empty or being taken,
// so a stalled receiver holds one result and then stops input.
// synchronous active-low reset turns all relays off, clears the counter,
// tick latch, markers and direction (closed) and sets channel enable to all
// ones; no result is pending after reset.
`default_nettype none

module relay_delay_sequencer #(
    parameter int NUM_CHANNELS = 8
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    rds_in_if.sink                       i_item,
    rds_out_if.source                    o_result,
    input  wire                          i_cfg_we,
    input  rds_pkg::t_cfg_idx            i_cfg_idx,
    input  wire [rds_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int LIVE = (NUM_CHANNELS > rds_pkg::MAX_CHANS) ?
                          rds_pkg::MAX_CHANS : NUM_CHANNELS;

    // configuration registers
    logic [rds_pkg::CFG_W-1:0] r_open_dly, r_close_dly;
    rds_pkg::t_byte            r_enable;

    // sequencer state
    rds_pkg::t_byte r_relay, n_relay;
    rds_pkg::t_byte r_cnt, n_cnt;
    logic           r_latch, n_latch;
    logic           r_dir, n_dir;
    logic           r_seq, n_seq;
    rds_pkg::t_mark r_om, n_om, r_omp, n_omp;
    rds_pkg::t_mark r_cm, n_cm, r_cmp, n_cmp;

    // result register
    logic           r_valid;
    rds_pkg::t_byte r_fired, n_fired;

    logic accept;

    assign i_item.ready = !r_valid || o_result.ready;
    assign accept       = i_item.valid && i_item.ready;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_dly  <= '0;
            r_close_dly <= '0;
            r_enable    <= rds_pkg::CHAN_ENABLE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rds_pkg::CFG_OPEN_DELAYS:  r_open_dly  <= i_cfg_data;
                rds_pkg::CFG_CLOSE_DELAYS: r_close_dly <= i_cfg_data;
                rds_pkg::CFG_CHAN_ENABLE:  r_enable    <= i_cfg_data[rds_pkg::DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    // one poll step
    always_comb begin
        logic [rds_pkg::CFG_W-1:0] dly_word;
        rds_pkg::t_mark            mark, prev;
        rds_pkg::t_byte            top, tgt;

        n_latch = r_latch | i_item.second_tick;
        n_cnt   = r_cnt;
        n_dir   = r_dir;
        n_seq   = r_seq;
        n_relay = r_relay;
        n_om    = r_om;
        n_omp   = r_omp;
        n_cm    = r_cm;
        n_cmp   = r_cmp;
        n_fired = '0;
        top     = '0;
        tgt     = '0;

        // tick advances the counter only while sequencing
        if (n_latch && r_seq) begin
            n_latch = 1'b0;
            n_cnt   = r_cnt + 8'd1;
        end

        // key press flips direction and restarts
        if (i_item.key_pressed) begin
            n_dir = !r_dir;
            n_seq = 1'b1;
            n_cnt = '0;
            if (n_dir) n_om = '0;
            else       n_cm = '0;
        end

        dly_word = n_dir ? r_open_dly : r_close_dly;
        mark     = n_dir ? n_om : n_cm;
        prev     = n_dir ? n_omp : n_cmp;

        if (n_seq) begin
            // per-channel compare, highest matching channel wins the marker
            for (int ch = 0; ch < LIVE; ch++) begin
                tgt = dly_word[rds_pkg::DELAY_W*ch +: rds_pkg::DELAY_W] + 8'd1;
                if (tgt > top) top = tgt;
                if (tgt == n_cnt) begin
                    if (n_dir) begin
                        if (r_enable[ch]) n_relay[ch] = 1'b1;
                    end else begin
                        n_relay[ch] = 1'b0;
                    end
                    mark = rds_pkg::MARK_W'(ch + 1);
                end
            end
            if (top == n_cnt) n_seq = 1'b0;
            if (mark != prev) begin
                prev    = mark;
                n_fired = n_cnt;
            end
            if (n_dir) begin
                n_om  = mark;
                n_omp = prev;
            end else begin
                n_cm  = mark;
                n_cmp = prev;
            end
        end
    end

    // state update on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relay <= '0;
            r_cnt   <= '0;
            r_latch <= 1'b0;
            r_dir   <= 1'b0;
            r_seq   <= 1'b0;
            r_om    <= '0;
            r_omp   <= '0;
            r_cm    <= '0;
            r_cmp   <= '0;
        end else if (accept) begin
            r_relay <= n_relay;
            r_cnt   <= n_cnt;
            r_latch <= n_latch;
            r_dir   <= n_dir;
            r_seq   <= n_seq;
            r_om    <= n_om;
            r_omp   <= n_omp;
            r_cm    <= n_cm;
            r_cmp   <= n_cmp;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fired <= '0;
        end else if (accept) begin
            r_fired <= n_fired;
        end
    end

    // relay and mode state always match the last result
    assign o_result.valid        = r_valid;
    assign o_result.fired_second = r_fired;
    assign o_result.relay_bits   = r_relay;
    assign o_result.dir_open     = r_dir;
    assign o_result.in_progress  = r_seq;

endmodule

`default_nettype wire

// ----- rtl/rds_checker.sv -----
`default_nettype none

module rds_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       i_in_ready,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire [7:0] i_relay_bits,
    input wire [7:0] i_fired_second
);

    // a pending result is held while the receiver stalls
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    // reset leaves no result pending
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // every accepted transaction gives a result next cycle
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> i_out_valid)
        else $error("missing result");

    // relay drive and fired second change only with an accepted transaction
    a_relay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_valid && i_in_ready) |=> $stable(i_relay_bits) && $stable(i_fired_second))
        else $error("result changed without input");

endmodule

bind relay_delay_sequencer rds_checker u_rds_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_item.valid),
    .i_in_ready     (i_item.ready),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_relay_bits   (o_result.relay_bits),
    .i_fired_second (o_result.fired_second)
);

`default_nettype wire
